// File: rtl/tat_pkg.sv
// Shared types, constants and trig table for the triangle affine transform.
package tat_pkg;

    localparam int COORD_WIDTH         = 16;
    localparam int TRIG_FRACTION_BITS  = 14;
    localparam int SCALE_FRACTION_BITS = 8;
    localparam int TABLE_BITS          = 14;
    localparam int ANGLE_WIDTH         = 16;
    localparam int SCALE_WIDTH         = 16;

    localparam int SUM_WIDTH   = COORD_WIDTH + 2;
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int TRIG_WIDTH  = TRIG_FRACTION_BITS + 2;
    localparam int COEF_WIDTH  = (TRIG_WIDTH > SCALE_WIDTH) ? TRIG_WIDTH : SCALE_WIDTH;
    localparam int PROD_WIDTH  = DIFF_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 1;
    localparam int RES_WIDTH   = ACC_WIDTH + 1;

    // Angle reduction: offset by a multiple of 360 so the angle is never negative,
    // then divide by 8 (shift) and by 45 through a reciprocal multiply.
    localparam int DEG_WIDTH        = 9;
    localparam int ANG_WIDTH        = ANGLE_WIDTH + 1;
    localparam int ANG_OFFSET       = 92 * 360;
    localparam int DEG_RECIP_WIDTH  = 11;
    localparam int DEG_SHIFT        = 16;
    localparam int DEG_RECIP        = (1 << DEG_SHIFT) / 45;
    localparam int DEG_Q_WIDTH      = 8;
    localparam int ANG_PROD_WIDTH   = ANG_WIDTH - 3 + DEG_RECIP_WIDTH;

    localparam logic [DEG_WIDTH-1:0] DEG_QUARTER = DEG_WIDTH'(90);
    localparam logic [DEG_WIDTH-1:0] DEG_HALF    = DEG_WIDTH'(180);
    localparam logic [DEG_WIDTH-1:0] DEG_3QUART  = DEG_WIDTH'(270);
    localparam logic [DEG_WIDTH-1:0] DEG_FULL    = DEG_WIDTH'(360);

    localparam int TRIG_UP   = (TRIG_FRACTION_BITS >= TABLE_BITS) ?
                               TRIG_FRACTION_BITS - TABLE_BITS : 0;
    localparam int TRIG_DOWN = (TRIG_FRACTION_BITS >= TABLE_BITS) ?
                               0 : TABLE_BITS - TRIG_FRACTION_BITS;

    typedef enum logic [1:0] {
        KIND_TRANSLATE = 2'd0,
        KIND_ROTATE    = 2'd1,
        KIND_SCALE     = 2'd2,
        KIND_PASS      = 2'd3
    } t_kind;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_kind                          kind;
        t_coord                         x0;
        t_coord                         y0;
        t_coord                         x1;
        t_coord                         y1;
        t_coord                         x2;
        t_coord                         y2;
        t_coord                         shift_x;
        t_coord                         shift_y;
        logic signed [ANGLE_WIDTH-1:0]  angle;
        logic signed [SCALE_WIDTH-1:0]  scale;
    } t_item;

    typedef struct packed {
        t_item                  item;
        t_coord                 cx;
        t_coord                 cy;
        logic [DEG_WIDTH-1:0]   deg;
    } t_prep;

    // First-quadrant sine per degree, unsigned Q1.14, rounded to nearest.
    localparam logic [TABLE_BITS:0] SIN_Q14 [0:90] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    function automatic logic [TRIG_WIDTH-1:0] quarter_entry(input logic [6:0] idx);
        logic [31:0] e;
        e = 32'(SIN_Q14[idx]) << TRIG_UP;
        e = (e + ((32'd1 << TRIG_DOWN) >> 1)) >> TRIG_DOWN;
        return TRIG_WIDTH'(e);
    endfunction

    function automatic logic signed [TRIG_WIDTH-1:0] sine_deg(input logic [DEG_WIDTH-1:0] d);
        logic [TRIG_WIDTH-1:0] m;
        logic                  neg;
        if (d < DEG_QUARTER) begin
            m   = quarter_entry(7'(d));
            neg = 1'b0;
        end else if (d < DEG_HALF) begin
            m   = quarter_entry(7'(DEG_HALF - d));
            neg = 1'b0;
        end else if (d < DEG_3QUART) begin
            m   = quarter_entry(7'(d - DEG_HALF));
            neg = 1'b1;
        end else begin
            m   = quarter_entry(7'(DEG_FULL - d));
            neg = 1'b1;
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

// File: rtl/tat_prep.sv
// Front pipeline: centroid by reciprocal division and angle reduction to 0..359.
module tat_prep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tat_pkg::t_item   i_item,
    output logic             o_valid,
    output tat_pkg::t_prep   o_prep
);

    localparam int CW  = tat_pkg::COORD_WIDTH;
    localparam int SW  = tat_pkg::SUM_WIDTH;
    localparam int MW  = tat_pkg::MAG_WIDTH;
    localparam int AW  = tat_pkg::ANG_WIDTH;
    localparam int PW  = tat_pkg::ANG_PROD_WIDTH;
    localparam int QW  = tat_pkg::DEG_Q_WIDTH;
    localparam int DW  = tat_pkg::DEG_WIDTH;
    // floor(2^MW / 3) underestimates the quotient by at most one.
    localparam logic [MW-1:0] RECIP3 = MW'((64'd1 << MW) / 3);

    // Stage A: coordinate sums and the offset angle.
    logic signed [SW-1:0] n_sum_x, n_sum_y;
    logic [AW-1:0]        n_ang;

    assign n_sum_x = SW'(i_item.x0) + SW'(i_item.x1) + SW'(i_item.x2);
    assign n_sum_y = SW'(i_item.y0) + SW'(i_item.y1) + SW'(i_item.y2);
    assign n_ang   = AW'(i_item.angle) + AW'(tat_pkg::ANG_OFFSET);

    logic                 r_a_valid;
    tat_pkg::t_item       r_a_item;
    logic                 r_a_neg_x, r_a_neg_y;
    logic [MW-1:0]        r_a_mag_x, r_a_mag_y;
    logic [AW-1:0]        r_a_ang;

    always_ff @(posedge i_clk) begin
        r_a_item  <= i_item;
        r_a_neg_x <= n_sum_x[SW-1];
        r_a_neg_y <= n_sum_y[SW-1];
        r_a_mag_x <= MW'(n_sum_x[SW-1] ? -n_sum_x : n_sum_x);
        r_a_mag_y <= MW'(n_sum_y[SW-1] ? -n_sum_y : n_sum_y);
        r_a_ang   <= n_ang;
    end

    // Stage B: reciprocal multiplies.
    logic [2*MW-1:0] n_prod_x, n_prod_y;
    logic [PW-1:0]   n_ang_prod;

    assign n_prod_x   = (2*MW)'(r_a_mag_x) * (2*MW)'(RECIP3);
    assign n_prod_y   = (2*MW)'(r_a_mag_y) * (2*MW)'(RECIP3);
    assign n_ang_prod = PW'(r_a_ang[AW-1:3]) * PW'(tat_pkg::DEG_RECIP);

    logic                 r_b_valid;
    tat_pkg::t_item       r_b_item;
    logic                 r_b_neg_x, r_b_neg_y;
    logic [MW-1:0]        r_b_mag_x, r_b_mag_y;
    logic [MW-1:0]        r_b_q_x, r_b_q_y;
    logic [AW-1:0]        r_b_ang;
    logic [QW-1:0]        r_b_qa;

    always_ff @(posedge i_clk) begin
        r_b_item  <= r_a_item;
        r_b_neg_x <= r_a_neg_x;
        r_b_neg_y <= r_a_neg_y;
        r_b_mag_x <= r_a_mag_x;
        r_b_mag_y <= r_a_mag_y;
        r_b_q_x   <= n_prod_x[2*MW-1:MW];
        r_b_q_y   <= n_prod_y[2*MW-1:MW];
        r_b_ang   <= r_a_ang;
        r_b_qa    <= n_ang_prod[tat_pkg::DEG_SHIFT +: QW];
    end

    // Stage C: quotient corrections, sign restore and angle remainder correction.
    logic [MW-1:0] n_rem_x, n_rem_y, n_qc_x, n_qc_y;
    logic [AW-1:0] n_ra;
    logic [AW-1:0] n_ra_fix;

    assign n_rem_x  = r_b_mag_x - MW'(r_b_q_x * MW'(3));
    assign n_rem_y  = r_b_mag_y - MW'(r_b_q_y * MW'(3));
    assign n_qc_x   = (n_rem_x >= MW'(3)) ? r_b_q_x + MW'(1) : r_b_q_x;
    assign n_qc_y   = (n_rem_y >= MW'(3)) ? r_b_q_y + MW'(1) : r_b_q_y;
    assign n_ra     = r_b_ang - AW'(r_b_qa) * AW'(tat_pkg::DEG_FULL);
    assign n_ra_fix = (n_ra >= AW'(tat_pkg::DEG_FULL)) ? n_ra - AW'(tat_pkg::DEG_FULL) : n_ra;

    logic           r_c_valid;
    tat_pkg::t_prep r_c_prep;

    always_ff @(posedge i_clk) begin
        r_c_prep.item <= r_b_item;
        r_c_prep.cx   <= CW'(r_b_neg_x ? -n_qc_x : n_qc_x);
        r_c_prep.cy   <= CW'(r_b_neg_y ? -n_qc_y : n_qc_y);
        r_c_prep.deg  <= DW'(n_ra_fix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    assign o_valid = r_c_valid;
    assign o_prep  = r_c_prep;

endmodule

// File: rtl/tat_lane.sv
// One vertex lane: offsets, products, truncating shift, centroid add and clamp.
module tat_lane (
    input  logic                                    i_clk,
    input  tat_pkg::t_kind                          i_kind,
    input  tat_pkg::t_coord                         i_x,
    input  tat_pkg::t_coord                         i_y,
    input  tat_pkg::t_coord                         i_cx,
    input  tat_pkg::t_coord                         i_cy,
    input  tat_pkg::t_coord                         i_shift_x,
    input  tat_pkg::t_coord                         i_shift_y,
    input  logic signed [tat_pkg::SCALE_WIDTH-1:0]  i_scale,
    input  logic signed [tat_pkg::TRIG_WIDTH-1:0]   i_sin,
    input  logic signed [tat_pkg::TRIG_WIDTH-1:0]   i_cos,
    output tat_pkg::t_coord                         o_x,
    output tat_pkg::t_coord                         o_y,
    output logic                                    o_sat
);

    localparam int CW  = tat_pkg::COORD_WIDTH;
    localparam int DW  = tat_pkg::DIFF_WIDTH;
    localparam int KW  = tat_pkg::COEF_WIDTH;
    localparam int PW  = tat_pkg::PROD_WIDTH;
    localparam int AW  = tat_pkg::ACC_WIDTH;
    localparam int RW  = tat_pkg::RES_WIDTH;
    localparam int TF  = tat_pkg::TRIG_FRACTION_BITS;
    localparam int SF  = tat_pkg::SCALE_FRACTION_BITS;
    localparam logic signed [AW-1:0] TRIG_BIAS  = AW'((64'd1 << TF) - 64'd1);
    localparam logic signed [AW-1:0] SCALE_BIAS = AW'((64'd1 << SF) - 64'd1);
    localparam logic signed [RW-1:0] MAX_V = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] MIN_V = -MAX_V - RW'(1);

    // Shift right with truncation toward zero; rotation and scale differ in shift.
    function automatic logic signed [AW-1:0] trunc_shift(input logic signed [AW-1:0] v,
                                                         input logic rot);
        logic signed [AW-1:0] t;
        logic signed [AW-1:0] s;
        t = v + (v[AW-1] ? TRIG_BIAS : AW'(0));
        s = v + (v[AW-1] ? SCALE_BIAS : AW'(0));
        return rot ? (t >>> TF) : (s >>> SF);
    endfunction

    // Stage 1: offsets from the centroid and translated coordinates.
    tat_pkg::t_kind                 r_s1_kind;
    logic signed [DW-1:0]           r_s1_dx, r_s1_dy, r_s1_tx, r_s1_ty;
    tat_pkg::t_coord                r_s1_x, r_s1_y, r_s1_cx, r_s1_cy;
    logic signed [tat_pkg::SCALE_WIDTH-1:0] r_s1_scale;

    always_ff @(posedge i_clk) begin
        r_s1_kind  <= i_kind;
        r_s1_dx    <= DW'(i_x) - DW'(i_cx);
        r_s1_dy    <= DW'(i_y) - DW'(i_cy);
        r_s1_tx    <= DW'(i_x) + DW'(i_shift_x);
        r_s1_ty    <= DW'(i_y) + DW'(i_shift_y);
        r_s1_x     <= i_x;
        r_s1_y     <= i_y;
        r_s1_cx    <= i_cx;
        r_s1_cy    <= i_cy;
        r_s1_scale <= i_scale;
    end

    // Stage 2: products. Scale reuses the cosine multipliers.
    logic signed [KW-1:0] n_kc;
    logic signed [PW-1:0] n_dx_e, n_dy_e, n_kc_e, n_ks_e;

    assign n_kc   = (r_s1_kind == tat_pkg::KIND_SCALE) ? KW'(r_s1_scale) : KW'(i_cos);
    assign n_dx_e = PW'(r_s1_dx);
    assign n_dy_e = PW'(r_s1_dy);
    assign n_kc_e = PW'(n_kc);
    assign n_ks_e = PW'(i_sin);

    tat_pkg::t_kind         r_s2_kind;
    logic signed [PW-1:0]   r_s2_p_xc, r_s2_p_ys, r_s2_p_xs, r_s2_p_yc;
    logic signed [DW-1:0]   r_s2_tx, r_s2_ty;
    tat_pkg::t_coord        r_s2_x, r_s2_y, r_s2_cx, r_s2_cy;

    always_ff @(posedge i_clk) begin
        r_s2_kind <= r_s1_kind;
        r_s2_p_xc <= n_dx_e * n_kc_e;
        r_s2_p_ys <= n_dy_e * n_ks_e;
        r_s2_p_xs <= n_dx_e * n_ks_e;
        r_s2_p_yc <= n_dy_e * n_kc_e;
        r_s2_tx   <= r_s1_tx;
        r_s2_ty   <= r_s1_ty;
        r_s2_x    <= r_s1_x;
        r_s2_y    <= r_s1_y;
        r_s2_cx   <= r_s1_cx;
        r_s2_cy   <= r_s1_cy;
    end

    // Stage 3: combine products and drop the fraction bits.
    logic                 n_rot;
    logic signed [AW-1:0] n_acc_x, n_acc_y;

    assign n_rot   = (r_s2_kind == tat_pkg::KIND_ROTATE);
    assign n_acc_x = n_rot ? AW'(r_s2_p_xc) - AW'(r_s2_p_ys) : AW'(r_s2_p_xc);
    assign n_acc_y = n_rot ? AW'(r_s2_p_xs) + AW'(r_s2_p_yc) : AW'(r_s2_p_yc);

    tat_pkg::t_kind         r_s3_kind;
    logic signed [AW-1:0]   r_s3_sh_x, r_s3_sh_y;
    logic signed [DW-1:0]   r_s3_tx, r_s3_ty;
    tat_pkg::t_coord        r_s3_x, r_s3_y, r_s3_cx, r_s3_cy;

    always_ff @(posedge i_clk) begin
        r_s3_kind <= r_s2_kind;
        r_s3_sh_x <= trunc_shift(n_acc_x, n_rot);
        r_s3_sh_y <= trunc_shift(n_acc_y, n_rot);
        r_s3_tx   <= r_s2_tx;
        r_s3_ty   <= r_s2_ty;
        r_s3_x    <= r_s2_x;
        r_s3_y    <= r_s2_y;
        r_s3_cx   <= r_s2_cx;
        r_s3_cy   <= r_s2_cy;
    end

    // Stage 4: select the result for the kind and saturate.
    logic signed [RW-1:0] n_vx, n_vy;
    logic                 n_hi_x, n_lo_x, n_hi_y, n_lo_y;

    always_comb begin
        case (r_s3_kind)
            tat_pkg::KIND_TRANSLATE: begin
                n_vx = RW'(r_s3_tx);
                n_vy = RW'(r_s3_ty);
            end
            tat_pkg::KIND_ROTATE, tat_pkg::KIND_SCALE: begin
                n_vx = RW'(r_s3_sh_x) + RW'(r_s3_cx);
                n_vy = RW'(r_s3_sh_y) + RW'(r_s3_cy);
            end
            default: begin
                n_vx = RW'(r_s3_x);
                n_vy = RW'(r_s3_y);
            end
        endcase
    end

    assign n_hi_x = (n_vx > MAX_V);
    assign n_lo_x = (n_vx < MIN_V);
    assign n_hi_y = (n_vy > MAX_V);
    assign n_lo_y = (n_vy < MIN_V);

    tat_pkg::t_coord r_s4_x, r_s4_y;
    logic            r_s4_sat;

    always_ff @(posedge i_clk) begin
        r_s4_x   <= n_hi_x ? CW'(MAX_V) : (n_lo_x ? CW'(MIN_V) : CW'(n_vx));
        r_s4_y   <= n_hi_y ? CW'(MAX_V) : (n_lo_y ? CW'(MIN_V) : CW'(n_vy));
        r_s4_sat <= n_hi_x | n_lo_x | n_hi_y | n_lo_y;
    end

    assign o_x   = r_s4_x;
    assign o_y   = r_s4_y;
    assign o_sat = r_s4_sat;

endmodule

// File: rtl/tat_xform.sv
// Back pipeline: sine and cosine lookup, three vertex lanes, and valid tracking.
module tat_xform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tat_pkg::t_prep     i_prep,
    output logic               o_valid,
    output tat_pkg::t_coord    o_x [3],
    output tat_pkg::t_coord    o_y [3],
    output tat_pkg::t_coord    o_cx,
    output tat_pkg::t_coord    o_cy,
    output logic               o_sat
);

    localparam int DW    = tat_pkg::DEG_WIDTH;
    localparam int DEPTH = 4;

    // Cosine is the sine of the angle advanced by a quarter turn.
    logic [DW-1:0] n_deg_c;

    assign n_deg_c = (i_prep.deg >= tat_pkg::DEG_3QUART) ? i_prep.deg - tat_pkg::DEG_3QUART
                                                         : i_prep.deg + tat_pkg::DEG_QUARTER;

    logic signed [tat_pkg::TRIG_WIDTH-1:0] r_sin, r_cos;

    always_ff @(posedge i_clk) begin
        r_sin <= tat_pkg::sine_deg(i_prep.deg);
        r_cos <= tat_pkg::sine_deg(n_deg_c);
    end

    tat_pkg::t_coord lane_x [3];
    tat_pkg::t_coord lane_y [3];
    logic [2:0]      lane_sat;

    assign lane_x[0] = i_prep.item.x0;
    assign lane_x[1] = i_prep.item.x1;
    assign lane_x[2] = i_prep.item.x2;
    assign lane_y[0] = i_prep.item.y0;
    assign lane_y[1] = i_prep.item.y1;
    assign lane_y[2] = i_prep.item.y2;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        tat_lane u_lane (
            .i_clk     (i_clk),
            .i_kind    (i_prep.item.kind),
            .i_x       (lane_x[g]),
            .i_y       (lane_y[g]),
            .i_cx      (i_prep.cx),
            .i_cy      (i_prep.cy),
            .i_shift_x (i_prep.item.shift_x),
            .i_shift_y (i_prep.item.shift_y),
            .i_scale   (i_prep.item.scale),
            .i_sin     (r_sin),
            .i_cos     (r_cos),
            .o_x       (o_x[g]),
            .o_y       (o_y[g]),
            .o_sat     (lane_sat[g])
        );
    end

    // The centroid and valid bit follow the lanes through the same four stages.
    logic [DEPTH-1:0] r_valid;
    tat_pkg::t_coord  r_cx [DEPTH];
    tat_pkg::t_coord  r_cy [DEPTH];

    always_ff @(posedge i_clk) begin
        r_cx[0] <= i_prep.cx;
        r_cy[0] <= i_prep.cy;
        for (int i = 1; i < DEPTH; i++) begin
            r_cx[i] <= r_cx[i-1];
            r_cy[i] <= r_cy[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_cx    = r_cx[DEPTH-1];
    assign o_cy    = r_cy[DEPTH-1];
    assign o_sat   = |lane_sat;

endmodule

// File: rtl/triangle_affine_transform.sv
// Top level of the triangle affine transform pipeline.
//
// A request is taken at each rising edge where start is high and busy is low.
// busy stays low: the block takes a new triangle in every cycle.
// Each request carries three vertices and a kind: translate by a shift,
// rotate about the centroid by whole degrees, or scale about the centroid
// by a signed Q8.8 factor. Any other kind passes the vertices through.
// The result appears for one cycle, marked by o_valid, together with the
// centroid and a saturation flag. Throughput is one triangle per cycle.
// The pipeline has three stages for the centroid division and angle
// reduction, then four for the trig lookup, the multipliers, the
// truncating shift and the clamp.
// The receiver cannot hold a result off, so nothing ever stalls the pipeline.
// A synchronous reset clears every valid bit; requests in flight are dropped
// and no result is shown until a new request has passed through.
module triangle_affine_transform (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              i_kind,
    input  logic signed [tat_pkg::COORD_WIDTH-1:0]  i_ax,
    input  logic signed [tat_pkg::COORD_WIDTH-1:0]  i_ay,
    input  logic signed [tat_pkg::COORD_WIDTH-1:0]  i_bx,
    input  logic signed [tat_pkg::COORD_WIDTH-1:0]  i_by_coord,
    input  logic signed [tat_pkg::COORD_WIDTH-1:0]  i_cx_in,
    input  logic signed [tat_pkg::COORD_WIDTH-1:0]  i_cy_in,
    input  logic signed [tat_pkg::COORD_WIDTH-1:0]  i_shift_x,
    input  logic signed [tat_pkg::COORD_WIDTH-1:0]  i_shift_y,
    input  logic signed [tat_pkg::ANGLE_WIDTH-1:0]  i_angle_deg,
    input  logic signed [tat_pkg::SCALE_WIDTH-1:0]  i_scale_q8,
    output logic                                    o_valid,
    output logic signed [tat_pkg::COORD_WIDTH-1:0]  o_out_ax,
    output logic signed [tat_pkg::COORD_WIDTH-1:0]  o_out_ay,
    output logic signed [tat_pkg::COORD_WIDTH-1:0]  o_out_bx,
    output logic signed [tat_pkg::COORD_WIDTH-1:0]  o_out_by,
    output logic signed [tat_pkg::COORD_WIDTH-1:0]  o_out_cx,
    output logic signed [tat_pkg::COORD_WIDTH-1:0]  o_out_cy,
    output logic signed [tat_pkg::COORD_WIDTH-1:0]  o_centroid_x,
    output logic signed [tat_pkg::COORD_WIDTH-1:0]  o_centroid_y,
    output logic                                    o_saturated
);

    tat_pkg::t_item  in_item;
    logic            in_valid;
    logic            prep_valid;
    tat_pkg::t_prep  prep;
    tat_pkg::t_coord res_x [3];
    tat_pkg::t_coord res_y [3];

    assign busy     = 1'b0;
    assign in_valid = start & ~busy;

    assign in_item.kind    = tat_pkg::t_kind'(i_kind);
    assign in_item.x0      = i_ax;
    assign in_item.y0      = i_ay;
    assign in_item.x1      = i_bx;
    assign in_item.y1      = i_by_coord;
    assign in_item.x2      = i_cx_in;
    assign in_item.y2      = i_cy_in;
    assign in_item.shift_x = i_shift_x;
    assign in_item.shift_y = i_shift_y;
    assign in_item.angle   = i_angle_deg;
    assign in_item.scale   = i_scale_q8;

    tat_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_item  (in_item),
        .o_valid (prep_valid),
        .o_prep  (prep)
    );

    tat_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .i_prep  (prep),
        .o_valid (o_valid),
        .o_x     (res_x),
        .o_y     (res_y),
        .o_cx    (o_centroid_x),
        .o_cy    (o_centroid_y),
        .o_sat   (o_saturated)
    );

    assign o_out_ax = res_x[0];
    assign o_out_ay = res_y[0];
    assign o_out_bx = res_x[1];
    assign o_out_by = res_y[1];
    assign o_out_cx = res_x[2];
    assign o_out_cy = res_y[2];

endmodule
